>>> hdl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// Line segment rasteriser package
// Widths, register indexes and sequencer states shared by the rasteriser
// and its divider.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam int CoordW    = 12;
  localparam int DiffW     = 13;
  localparam int DimW      = 7;
  localparam int PixW      = 6;
  localparam int SlopeBits = 16;
  localparam int NumW      = 28;
  localparam int DenW      = 12;
  localparam int CntW      = 5;
  localparam int SlopeW    = 29;
  localparam int OffW      = 16;
  localparam int ProdW     = 45;
  localparam int AccW      = 48;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_INIT,
    ST_STEP,
    ST_FLUSH
  } state_t;

endpackage

>>> hdl/lsr_divider.sv
// ----------------------------------------------------------------------------
// Slope divider
// Restoring unsigned divider, one quotient bit per cycle. Pulses done for a
// single cycle, set at the same clock edge that registers the last quotient bit.
// ----------------------------------------------------------------------------
module lsr_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lsr_pkg::NumW-1:0]  numer,
  input  logic [lsr_pkg::DenW-1:0]  denom,
  output logic                      done,
  output logic [lsr_pkg::NumW-1:0]  quot
);

  logic                      busy;
  logic [lsr_pkg::CntW-1:0]  cnt;
  logic [lsr_pkg::DenW-1:0]  rem;
  logic [lsr_pkg::DenW-1:0]  den;
  logic [lsr_pkg::NumW-1:0]  nq;
  logic [lsr_pkg::DenW:0]    trial;
  logic [lsr_pkg::DenW+1:0]  diff;
  logic                      ge;

  always_comb begin
    trial = {rem, nq[lsr_pkg::NumW-1]};
    diff  = {1'b0, trial} - {2'b00, den};
    ge    = !diff[lsr_pkg::DenW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == lsr_pkg::CntW'(lsr_pkg::NumW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      nq  <= numer;
      den <= denom;
    end else if (busy) begin
      cnt <= cnt + lsr_pkg::CntW'(1);
      rem <= ge ? diff[lsr_pkg::DenW-1:0] : trial[lsr_pkg::DenW-1:0];
      nq  <= {nq[lsr_pkg::NumW-2:0], ge};
    end
  end

  assign quot = nq;

endmodule

>>> hdl/line_segment_rasterizer.sv
// ----------------------------------------------------------------------------
// Line segment rasteriser
// Slope-based DDA: one segment in, its on-screen pixels out in rising
// major-axis order, the final one flagged by last_pixel.
//
// Input channel: in_valid/in_stall carries the two Q8.4 endpoints. in_stall
// is high from the transfer of a segment until its last pixel has been
// handed to the output register, so one segment is in flight at a time.
// Output channel: out_valid/out_stall carries pixel_x, pixel_y, last_pixel
// from an output register; a stalled pixel holds and the stepper waits.
// Per segment: the setup states SETUP and DECIDE, the restoring divider for
// the slope (28 quotient bits), a multiply and an add step, then one major
// column or row per cycle (at most MAX_DIM) unless a pixel waits on a stalled
// output, then a flush step for the final pixel.
// Segments with neither endpoint on screen leave after DECIDE, without a divide.
// Screen size is written on the cfg port, which the user must do only while
// idle (not enforced); reset sets both to 64, clears sequencer and out_valid.
// ----------------------------------------------------------------------------
module line_segment_rasterizer #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [lsr_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [lsr_pkg::DimW-1:0]              cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lsr_pkg::CoordW-1:0]     start_x,
  input  logic signed [lsr_pkg::CoordW-1:0]     start_y,
  input  logic signed [lsr_pkg::CoordW-1:0]     finish_x,
  input  logic signed [lsr_pkg::CoordW-1:0]     finish_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lsr_pkg::PixW-1:0]              pixel_x,
  output logic [lsr_pkg::PixW-1:0]              pixel_y,
  output logic                                  last_pixel
);

  localparam int CW = lsr_pkg::CoordW;
  localparam int DW = lsr_pkg::DiffW;
  localparam int MW = lsr_pkg::DimW;
  localparam int PW = lsr_pkg::PixW;
  localparam int AW = lsr_pkg::AccW;
  localparam int FracAll = lsr_pkg::SlopeBits + FRAC_BITS;
  localparam logic [MW-1:0] MaxDim = MW'(MAX_DIM);

  lsr_pkg::state_t state, state_next;

  logic [MW-1:0] screen_width, screen_height;

  logic signed [CW-1:0] x1, y1, x2, y2;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady;
  logic                 on1, on2;
  logic [MW-1:0]        w, h;

  logic                 xmajor;
  logic signed [CW-1:0] maj1, min1;
  logic [PW-1:0]        first, last;
  logic                 empty;
  logic [MW-1:0]        minsize;
  logic                 neg;

  logic signed [lsr_pkg::SlopeW-1:0] slope;
  logic signed [lsr_pkg::ProdW-1:0]  prod;
  logic signed [AW-1:0]              acc;
  logic [PW-1:0]                     idx;

  logic          pend_valid;
  logic [PW-1:0] pend_x, pend_y;

  logic                      div_start, div_done;
  logic [lsr_pkg::NumW-1:0]  div_numer, div_quot;
  logic [lsr_pkg::DenW-1:0]  div_denom;

  // setup, SETUP state
  logic [MW-1:0]        w_c, h_c;
  logic signed [DW-1:0] dx_c, dy_c;
  logic [DW-1:0]        adx_c, ady_c;

  // setup, DECIDE state
  logic                 xmajor_c, zero_c, visible_c;
  logic signed [CW-1:0] maj1_c, maj2_c, min1_c, lo_c, hi_c, last_s_c;
  logic signed [DW-1:0] dmaj_c, dmin_c;
  logic [DW-1:0]        admaj_c, admin_c;
  logic [CW-1:0]        first_c, last_cl_c;
  logic [MW-1:0]        majsize_c;

  // stepping
  logic signed [lsr_pkg::OffW-1:0] off;
  logic signed [AW-1:0]            m_floor;
  logic                            hit;
  logic [PW-1:0]                   m_pix, hit_x, hit_y;
  logic                            out_free, step_adv, emit, emit_last;

  function automatic logic on_screen(input logic signed [CW-1:0] px,
                                     input logic signed [CW-1:0] py,
                                     input logic [MW-1:0] sw,
                                     input logic [MW-1:0] sh);
    logic [CW-1:0] ix, iy;
    ix = CW'(px >>> FRAC_BITS);
    iy = CW'(py >>> FRAC_BITS);
    return !px[CW-1] && !py[CW-1] && (ix < CW'(sw)) && (iy < CW'(sh));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= MW'(64);
      screen_height <= MW'(64);
    end else if (cfg_write) begin
      case (cfg_index)
        lsr_pkg::REG_WIDTH:  screen_width  <= cfg_data;
        lsr_pkg::REG_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c   = (screen_width  > MaxDim) ? MaxDim : screen_width;
    h_c   = (screen_height > MaxDim) ? MaxDim : screen_height;
    dx_c  = {x1[CW-1], x1} - {x2[CW-1], x2};
    dy_c  = {y1[CW-1], y1} - {y2[CW-1], y2};
    adx_c = (dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c)) >> FRAC_BITS;
    ady_c = (dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c)) >> FRAC_BITS;
  end

  always_comb begin
    visible_c = on1 || on2;
    zero_c    = (adx == '0) && (ady == '0);
    xmajor_c  = adx >= ady;
    maj1_c    = xmajor_c ? x1 : y1;
    maj2_c    = xmajor_c ? x2 : y2;
    min1_c    = xmajor_c ? y1 : x1;
    majsize_c = xmajor_c ? w : h;
    dmaj_c    = xmajor_c ? DW'(-dx) : DW'(-dy);
    dmin_c    = xmajor_c ? DW'(-dy) : DW'(-dx);
    admaj_c   = dmaj_c[DW-1] ? DW'(-dmaj_c) : DW'(dmaj_c);
    admin_c   = dmin_c[DW-1] ? DW'(-dmin_c) : DW'(dmin_c);
    lo_c      = dmaj_c[DW-1] ? maj2_c : maj1_c;
    hi_c      = dmaj_c[DW-1] ? maj1_c : maj2_c;
    first_c   = lo_c[CW-1] ? '0 : CW'(lo_c >>> FRAC_BITS);
    last_s_c  = hi_c >>> FRAC_BITS;
    last_cl_c = ($signed(last_s_c) > $signed(CW'(majsize_c) - CW'(1))) ?
                (CW'(majsize_c) - CW'(1)) : CW'(last_s_c);
    div_numer = {admin_c[lsr_pkg::DenW-1:0], {lsr_pkg::SlopeBits{1'b0}}};
    div_denom = admaj_c[lsr_pkg::DenW-1:0];
  end

  lsr_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    off     = $signed(lsr_pkg::OffW'({{(lsr_pkg::OffW-PW){1'b0}}, first} << FRAC_BITS))
              - {{(lsr_pkg::OffW-CW){maj1[CW-1]}}, maj1};
    m_floor = acc >>> FracAll;
    hit     = (!acc[AW-1] && (m_floor < $signed({{(AW-MW){1'b0}}, minsize}))) ||
              ((m_floor == -AW'(1)) && (acc[FracAll-1:0] != '0));
    m_pix   = acc[AW-1] ? '0 : m_floor[PW-1:0];
    hit_x   = xmajor ? idx : m_pix;
    hit_y   = xmajor ? m_pix : idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lsr_pkg::ST_IDLE:   if (in_valid) state_next = lsr_pkg::ST_SETUP;
      lsr_pkg::ST_SETUP:  state_next = lsr_pkg::ST_DECIDE;
      lsr_pkg::ST_DECIDE: begin
        if (!visible_c) begin
          state_next = lsr_pkg::ST_IDLE;
        end else if (zero_c) begin
          state_next = on1 ? lsr_pkg::ST_FLUSH : lsr_pkg::ST_IDLE;
        end else begin
          state_next = lsr_pkg::ST_DIV;
        end
      end
      lsr_pkg::ST_DIV:    if (div_done) state_next = lsr_pkg::ST_MUL;
      lsr_pkg::ST_MUL:    state_next = lsr_pkg::ST_INIT;
      lsr_pkg::ST_INIT:   state_next = empty ? lsr_pkg::ST_FLUSH : lsr_pkg::ST_STEP;
      lsr_pkg::ST_STEP:   if (step_adv && idx == last) state_next = lsr_pkg::ST_FLUSH;
      lsr_pkg::ST_FLUSH:  if (!pend_valid || out_free) state_next = lsr_pkg::ST_IDLE;
      default:            state_next = lsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_free  = !out_valid || !out_stall;
    in_stall  = (state != lsr_pkg::ST_IDLE);
    div_start = (state == lsr_pkg::ST_DECIDE) && visible_c && !zero_c;
    step_adv  = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    case (state)
      lsr_pkg::ST_STEP: begin
        step_adv = !(hit && pend_valid && !out_free);
        emit     = step_adv && hit && pend_valid;
      end
      lsr_pkg::ST_FLUSH: begin
        emit      = pend_valid && out_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      lsr_pkg::ST_IDLE: begin
        x1 <= start_x;
        y1 <= start_y;
        x2 <= finish_x;
        y2 <= finish_y;
      end
      lsr_pkg::ST_SETUP: begin
        w   <= w_c;
        h   <= h_c;
        dx  <= dx_c;
        dy  <= dy_c;
        adx <= adx_c;
        ady <= ady_c;
        on1 <= on_screen(x1, y1, w_c, h_c);
        on2 <= on_screen(x2, y2, w_c, h_c);
      end
      lsr_pkg::ST_DECIDE: begin
        xmajor  <= xmajor_c;
        maj1    <= maj1_c;
        min1    <= min1_c;
        minsize <= xmajor_c ? h : w;
        neg     <= dmaj_c[DW-1] ^ dmin_c[DW-1];
        first   <= first_c[PW-1:0];
        last    <= last_cl_c[PW-1:0];
        empty   <= last_s_c[CW-1] || (first_c > last_cl_c);
        pend_x  <= PW'(x1 >>> FRAC_BITS);
        pend_y  <= PW'(y1 >>> FRAC_BITS);
      end
      lsr_pkg::ST_DIV: begin
        slope <= neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
      end
      lsr_pkg::ST_MUL: begin
        prod <= lsr_pkg::ProdW'(slope) * lsr_pkg::ProdW'(off);
      end
      lsr_pkg::ST_INIT: begin
        acc <= $signed({{(AW-CW-lsr_pkg::SlopeBits){min1[CW-1]}}, min1,
                        {lsr_pkg::SlopeBits{1'b0}}}) + AW'(prod);
        idx <= first;
      end
      lsr_pkg::ST_STEP: begin
        if (step_adv) begin
          acc <= acc + (AW'(slope) <<< FRAC_BITS);
          idx <= idx + PW'(1);
          if (hit) begin
            pend_x <= hit_x;
            pend_y <= hit_y;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (state == lsr_pkg::ST_DECIDE) begin
      pend_valid <= visible_c && zero_c && on1;
    end else if (state == lsr_pkg::ST_STEP && step_adv && hit) begin
      pend_valid <= 1'b1;
    end else if (state == lsr_pkg::ST_FLUSH && emit) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= pend_x;
      pixel_y    <= pend_y;
      last_pixel <= emit_last;
    end
  end

endmodule

>>> verif/line_segment_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// Line segment rasteriser checker
// Tracks the screen size written on the cfg port, works out the pixels of
// every segment transfer and compares each pixel transfer, field by field,
// with the oldest pixel still due. Hands its failure count and the number of
// pixels still due to the testbench top.
// ----------------------------------------------------------------------------
module line_segment_rasterizer_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lsr_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [lsr_pkg::DimW-1:0]          cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [lsr_pkg::CoordW-1:0] start_x,
  input  logic signed [lsr_pkg::CoordW-1:0] start_y,
  input  logic signed [lsr_pkg::CoordW-1:0] finish_x,
  input  logic signed [lsr_pkg::CoordW-1:0] finish_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [lsr_pkg::PixW-1:0]          pixel_x,
  input  logic [lsr_pkg::PixW-1:0]          pixel_y,
  input  logic                              last_pixel,
  output int                                failures,
  output int                                pixels_due
);

  localparam int     FracBits = 4;
  localparam int     MaxDim   = 64;
  localparam longint PixScale = longint'(1) << FracBits;
  localparam longint SlopeOne = longint'(1) << lsr_pkg::SlopeBits;
  localparam longint AccOne   = longint'(1) << (lsr_pkg::SlopeBits + FracBits);

  typedef struct packed {
    logic [lsr_pkg::PixW-1:0] x;
    logic [lsr_pkg::PixW-1:0] y;
    logic                     last;
  } pixel_t;

  pixel_t                   due_pixels[$];
  logic [lsr_pkg::DimW-1:0] screen_w;
  logic [lsr_pkg::DimW-1:0] screen_h;
  int                       fail_count;

  function automatic longint clamp_dim(input logic [lsr_pkg::DimW-1:0] v);
    return (v > MaxDim) ? longint'(MaxDim) : longint'(v);
  endfunction

  function automatic bit visible(input longint x, input longint y,
                                 input longint w, input longint h);
    return x >= 0 && y >= 0 && x / PixScale < w && y / PixScale < h;
  endfunction

  function automatic longint floor_pixel(input longint v);
    return (v >= 0) ? v / PixScale : -((-v + PixScale - 1) / PixScale);
  endfunction

  task automatic rasterise(input logic signed [lsr_pkg::CoordW-1:0] sx,
                           input logic signed [lsr_pkg::CoordW-1:0] sy,
                           input logic signed [lsr_pkg::CoordW-1:0] fx,
                           input logic signed [lsr_pkg::CoordW-1:0] fy);
    longint x1, y1, x2, y2, w, h, tdx, tdy;
    longint maj1, maj2, min1, min2, maj_size, min_size;
    longint slope, lo, hi, first_px, last_px, acc, m;
    bit     xmajor;
    bit     held;
    int     n;
    pixel_t px;
    x1 = sx;
    y1 = sy;
    x2 = fx;
    y2 = fy;
    w  = clamp_dim(screen_w);
    h  = clamp_dim(screen_h);
    if (!visible(x1, y1, w, h) && !visible(x2, y2, w, h)) return;
    tdx = (x1 - x2) / PixScale;
    tdy = (y1 - y2) / PixScale;
    if (tdx == 0 && tdy == 0) begin
      if (visible(x1, y1, w, h)) begin
        px.x    = lsr_pkg::PixW'(x1 / PixScale);
        px.y    = lsr_pkg::PixW'(y1 / PixScale);
        px.last = 1'b1;
        due_pixels.push_back(px);
      end
      return;
    end
    // equal spans count as x-major
    xmajor = ((tdx < 0) ? -tdx : tdx) >= ((tdy < 0) ? -tdy : tdy);
    if (xmajor) begin
      maj1 = x1; maj2 = x2; min1 = y1; min2 = y2; maj_size = w; min_size = h;
    end else begin
      maj1 = y1; maj2 = y2; min1 = x1; min2 = x2; maj_size = h; min_size = w;
    end
    slope    = ((min2 - min1) * SlopeOne) / (maj2 - maj1);
    lo       = (maj1 < maj2) ? maj1 : maj2;
    hi       = (maj1 < maj2) ? maj2 : maj1;
    first_px = lo / PixScale;
    last_px  = floor_pixel(hi);
    if (first_px < 0) first_px = 0;
    if (last_px > maj_size - 1) last_px = maj_size - 1;
    n    = 0;
    held = 1'b0;
    for (longint i = first_px; i <= last_px; i++) begin
      acc = min1 * SlopeOne + slope * (i * PixScale - maj1);
      m   = acc / AccOne;
      if (m < 0 || m >= min_size || n >= MaxDim) continue;
      if (held) due_pixels.push_back(px);
      px.x    = xmajor ? lsr_pkg::PixW'(i) : lsr_pkg::PixW'(m);
      px.y    = xmajor ? lsr_pkg::PixW'(m) : lsr_pkg::PixW'(i);
      px.last = 1'b0;
      held    = 1'b1;
      n++;
    end
    if (held) begin
      px.last = 1'b1;
      due_pixels.push_back(px);
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_t px;
    if (rst) begin
      screen_w   = 7'd64;
      screen_h   = 7'd64;
      fail_count = 0;
      due_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: pixel x=%0d y=%0d last=%0b with none expected",
                   $time, pixel_x, pixel_y, last_pixel);
          fail_count++;
        end else begin
          px = due_pixels.pop_front();
          if (px.x !== pixel_x || px.y !== pixel_y || px.last !== last_pixel) begin
            $display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b, ",
                      "got x=%0d y=%0d last=%0b"},
                     $time, px.x, px.y, px.last, pixel_x, pixel_y, last_pixel);
            fail_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          lsr_pkg::REG_WIDTH:  screen_w = cfg_data;
          lsr_pkg::REG_HEIGHT: screen_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) rasterise(start_x, start_y, finish_x, finish_y);
    end
    failures   <= fail_count;
    pixels_due <= due_pixels.size();
  end

endmodule

>>> verif/line_segment_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// Line segment rasteriser testbench
// Resets the rasteriser, sends a directed set of segments at the reset screen
// size, then random segments over a series of screen sizes including the
// extremes, with random gaps on the segment side and random stalls on the
// pixel side. The checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module line_segment_rasterizer_tb;

  localparam logic [lsr_pkg::CfgIdxW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [lsr_pkg::CfgIdxW-1:0] REG_SPARE_HI = 2'd3;
  localparam int                          SettleCycles = 120;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_write;
  logic [lsr_pkg::CfgIdxW-1:0]       cfg_index;
  logic [lsr_pkg::DimW-1:0]          cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [lsr_pkg::CoordW-1:0] start_x;
  logic signed [lsr_pkg::CoordW-1:0] start_y;
  logic signed [lsr_pkg::CoordW-1:0] finish_x;
  logic signed [lsr_pkg::CoordW-1:0] finish_y;
  logic                              out_valid;
  logic                              out_stall;
  logic [lsr_pkg::PixW-1:0]          pixel_x;
  logic [lsr_pkg::PixW-1:0]          pixel_y;
  logic                              last_pixel;
  int                                failures;
  int                                pixels_due;
  int                                view_w;
  int                                view_h;
  bit                                sender_calm;

  always #10 clk = ~clk;

  line_segment_rasterizer u_dut (.*);

  line_segment_rasterizer_checker u_checker (.*);

  initial begin
    #150_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [lsr_pkg::CoordW-1:0] coord_near(input int dim);
    return lsr_pkg::CoordW'(int'($urandom_range(0, dim * 16 + 256)) - 128);
  endfunction

  // alternate calm stretches with bursts of random stalls
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (gap_length()) @(posedge clk);
        out_stall <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end
    end
  end

  task automatic send_segment(input logic signed [lsr_pkg::CoordW-1:0] sx,
                              input logic signed [lsr_pkg::CoordW-1:0] sy,
                              input logic signed [lsr_pkg::CoordW-1:0] fx,
                              input logic signed [lsr_pkg::CoordW-1:0] fy);
    int gap;
    gap = (sender_calm || $urandom_range(0, 2) == 0) ? 0 : gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    finish_x <= fx;
    finish_y <= fy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every pixel due has arrived and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_screen(input logic [lsr_pkg::DimW-1:0] w,
                            input logic [lsr_pkg::DimW-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_data  <= lsr_pkg::DimW'($urandom);
    @(posedge clk);
    cfg_index <= lsr_pkg::REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= lsr_pkg::REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    view_w = (w > 64) ? 64 : ((w == 0) ? 1 : int'(w));
    view_h = (h > 64) ? 64 : ((h == 0) ? 1 : int'(h));
  endtask

  task automatic run_phase(input logic [lsr_pkg::DimW-1:0] w,
                           input logic [lsr_pkg::DimW-1:0] h, input int count);
    int                                kind;
    int                                d;
    int                                pause_at;
    logic signed [lsr_pkg::CoordW-1:0] sx, sy, fx, fy;
    set_screen(w, h);
    sender_calm = ($urandom_range(0, 3) == 0);
    pause_at    = $urandom_range(0, count - 1);
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      sx   = coord_near(view_w);
      sy   = coord_near(view_h);
      fx   = coord_near(view_w);
      fy   = coord_near(view_h);
      if (kind >= 55 && kind < 70) begin
        if ($urandom_range(0, 1)) {sx, sy} = 24'($urandom_range(0, 24'hFFFFFF));
        else {fx, fy} = 24'($urandom_range(0, 24'hFFFFFF));
      end else if (kind >= 70 && kind < 82) begin
        fx = lsr_pkg::CoordW'(int'(sx) + int'($urandom_range(0, 40)) - 20);
        fy = lsr_pkg::CoordW'(int'(sy) + int'($urandom_range(0, 40)) - 20);
      end else if (kind >= 82 && kind < 90) begin
        d  = $urandom_range(16, 600);
        fx = lsr_pkg::CoordW'($urandom_range(0, 1) ? int'(sx) + d : int'(sx) - d);
        fy = lsr_pkg::CoordW'($urandom_range(0, 1) ? int'(sy) + d : int'(sy) - d);
      end else if (kind >= 90) begin
        {sx, sy} = 24'($urandom_range(0, 24'hFFFFFF));
        {fx, fy} = 24'($urandom_range(0, 24'hFFFFFF));
      end
      send_segment(sx, sy, fx, fy);
      if (k == pause_at) drain();
    end
    drain();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= lsr_pkg::REG_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    start_x   <= '0;
    start_y   <= '0;
    finish_x  <= '0;
    finish_y  <= '0;
    view_w      = 64;
    view_h      = 64;
    sender_calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_segment(-16, -16, -32, -80);
    send_segment(88, 116, 94, 120);
    send_segment(-8, 16, 4, 20);
    send_segment(0, 160, 1023, 160);
    send_segment(320, 1023, 320, 0);
    send_segment(0, 0, 1023, 1023);
    send_segment(1023, 0, 0, 1023);
    send_segment(-2048, 500, 500, 500);
    send_segment(2047, 2047, 100, 100);
    send_segment(-2048, 2047, 300, 200);
    send_segment(16, 0, 48, 1000);
    send_segment(0, 100, 1000, -2000);
    send_segment(1024, 1024, 1023, 1023);
    send_segment(1023, 1023, 1024, 1024);
    send_segment(-2048, -2048, 2047, 2047);
    send_segment(2047, -2048, 0, 0);
    send_segment(40, 40, 8, 24);
    send_segment(-24, 10, 40, 10);
    send_segment(500, 300, 516, 316);
    send_segment(7, 7, -7, -7);
    drain();

    run_phase(7'd1, 7'd1, 15);
    run_phase(7'd127, 7'd127, 35);
    run_phase(7'd0, 7'd64, 10);
    run_phase(7'd64, 7'd0, 10);
    run_phase(7'd64, 7'd64, 30);
    repeat (6) run_phase(lsr_pkg::DimW'($urandom_range(1, 72)),
                         lsr_pkg::DimW'($urandom_range(1, 72)), 25);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
